// ----- rtl/core/lru_page_replacement_defines.svh -----
// Assertion macros used by the page replacement RTL.
`ifndef LRU_PAGE_REPLACEMENT_DEFINES_SVH
`define LRU_PAGE_REPLACEMENT_DEFINES_SVH

// Checks that the consequent holds in the same cycle as the antecedent.
`define LRU_ASSERT_SAME(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Checks that the consequent holds in the cycle after the antecedent.
`define LRU_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- rtl/core/lru_pkg.sv -----
// Types and fixed field widths of the LRU page replacement block.
package lru_pkg;

	localparam int ADDR_W  = 16;
	localparam int PAGE_W  = 13;
	localparam int FRAME_W = 5;
	localparam int FAULT_W = 16;
	localparam int CFG_W   = 6;

	localparam logic [CFG_W-1:0] CFG_RESET = 6'd4;

	typedef logic [PAGE_W-1:0]  page_t;
	typedef logic [FAULT_W-1:0] fault_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_DRAIN,
		ST_UPDATE
	} state_t;

endpackage

// ----- rtl/core/lru_page_replacement.sv -----
// LRU page replacement unit: page lookup, fill or eviction, and fault counting.
// Each accepted address beat is handled in order: on acceptance the page number is
// formed with a reciprocal multiply, the scan reads the page memory one frame per
// cycle over the active frames through its single read port while one compare stage
// looks for the hit, the first empty frame and the oldest frame, a drain state
// empties that stage, and an update state updates the ranks and writes the page
// memory. The update state waits while the previous result beat has not been taken.
// The page memory needs no clearing after reset, as each frame has a valid flag that
// reset clears. The configuration channel is always ready; a frame count of zero
// acts as one and one above MAX_FRAMES as MAX_FRAMES.
`include "lru_page_replacement_defines.svh"

module lru_page_replacement #(
	parameter int MAX_FRAMES = 32,
	parameter int PAGE_WORDS = 10
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cfg_valid,
	output logic                        cfg_ready,
	input  logic [lru_pkg::CFG_W-1:0]   cfg_data,
	input  logic                        in_valid,
	output logic                        in_ready,
	input  logic [lru_pkg::ADDR_W-1:0]  address,
	output logic                        out_valid,
	input  logic                        out_ready,
	output logic                        hit,
	output logic [lru_pkg::FRAME_W-1:0] frame,
	output logic                        evicted_valid,
	output logic [lru_pkg::PAGE_W-1:0]  evicted_page,
	output logic [lru_pkg::FAULT_W-1:0] fault_count
);

	localparam int IW     = (MAX_FRAMES > 1) ? $clog2(MAX_FRAMES) : 1;
	localparam int CW     = $clog2(MAX_FRAMES + 1);
	localparam int SHIFT  = lru_pkg::ADDR_W + $clog2(PAGE_WORDS);
	localparam int PROD_W = SHIFT + lru_pkg::PAGE_W;
	localparam logic [PROD_W-1:0] MULT =
		PROD_W'((64'd1 << SHIFT) / 64'(PAGE_WORDS) + 64'd1);
	localparam logic [IW-1:0] RANK_MAX = IW'(MAX_FRAMES - 1);

	lru_pkg::state_t state_q, state_d;

	logic [lru_pkg::CFG_W-1:0] cfg_q;
	logic [PROD_W-1:0]         prod_q;
	lru_pkg::page_t            page;
	logic [CW-1:0]             n_act;
	logic [CW-1:0]             n_q;

	logic [MAX_FRAMES-1:0]     valid_q;
	logic [IW-1:0]             rank_q [MAX_FRAMES];
	lru_pkg::page_t            page_mem [MAX_FRAMES];

	logic [IW-1:0]             rd_idx_q;
	logic                      cmp_vld_s1;
	logic [IW-1:0]             idx_s1;
	lru_pkg::page_t            rd_data_s1;

	logic                      hit_found_q;
	logic [IW-1:0]             hit_idx_q;
	logic [IW-1:0]             hit_rank_q;
	logic                      empty_found_q;
	logic [IW-1:0]             empty_idx_q;
	logic [IW-1:0]             best_rank_q;
	logic [IW-1:0]             vic_idx_q;
	lru_pkg::page_t            vic_page_q;

	lru_pkg::fault_t           fault_q;
	logic                      out_valid_q;
	logic                      hit_q;
	logic [lru_pkg::FRAME_W-1:0] frame_q;
	logic                      ev_valid_q;
	lru_pkg::page_t            ev_page_q;

	logic                      in_fire;
	logic                      scan_rd;
	logic                      scan_last;
	logic                      upd_go;
	logic [IW-1:0]             upd_frame;
	logic [IW-1:0]             upd_old_rank;
	logic                      upd_fill;
	logic [IW+lru_pkg::FRAME_W-1:0] frame_ext;
	logic                      cmp_valid;
	logic [IW-1:0]             cmp_rank;

	assign page      = prod_q[SHIFT +: lru_pkg::PAGE_W];
	assign cfg_ready = 1'b1;
	assign in_fire   = in_valid && in_ready;
	assign scan_last = (CW'(rd_idx_q) + CW'(1)) == n_q;
	assign cmp_valid = valid_q[idx_s1];
	assign cmp_rank  = rank_q[idx_s1];

	always_comb begin
		if (cfg_q == '0) begin
			n_act = CW'(1);
		end else if (7'(cfg_q) > 7'(MAX_FRAMES)) begin
			n_act = CW'(MAX_FRAMES);
		end else begin
			n_act = CW'(cfg_q);
		end
	end

	always_comb begin
		if (hit_found_q) begin
			upd_frame    = hit_idx_q;
			upd_old_rank = hit_rank_q;
			upd_fill     = 1'b0;
		end else if (empty_found_q) begin
			upd_frame    = empty_idx_q;
			upd_old_rank = '0;
			upd_fill     = 1'b1;
		end else begin
			upd_frame    = vic_idx_q;
			upd_old_rank = best_rank_q;
			upd_fill     = 1'b0;
		end
	end

	assign frame_ext = {{lru_pkg::FRAME_W{1'b0}}, upd_frame};

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			lru_pkg::ST_IDLE: begin
				if (in_fire) state_d = lru_pkg::ST_SCAN;
			end
			lru_pkg::ST_SCAN: begin
				if (scan_last) state_d = lru_pkg::ST_DRAIN;
			end
			lru_pkg::ST_DRAIN: begin
				state_d = lru_pkg::ST_UPDATE;
			end
			lru_pkg::ST_UPDATE: begin
				if (upd_go) state_d = lru_pkg::ST_IDLE;
			end
			default: state_d = lru_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		in_ready = 1'b0;
		scan_rd  = 1'b0;
		upd_go   = 1'b0;
		unique case (state_q)
			lru_pkg::ST_IDLE:   in_ready = 1'b1;
			lru_pkg::ST_SCAN:   scan_rd  = 1'b1;
			lru_pkg::ST_DRAIN:  scan_rd  = 1'b0;
			lru_pkg::ST_UPDATE: upd_go   = !out_valid_q || out_ready;
			default:            in_ready = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= lru_pkg::ST_IDLE;
			cfg_q   <= lru_pkg::CFG_RESET;
		end else begin
			state_q <= state_d;
			if (cfg_valid && cfg_ready) cfg_q <= cfg_data;
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			prod_q <= PROD_W'(address) * MULT;
			n_q    <= n_act;
		end
	end

	always_ff @(posedge clk) begin
		if (upd_go && !hit_found_q) page_mem[upd_frame] <= page;
		if (scan_rd) rd_data_s1 <= page_mem[rd_idx_q];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_idx_q   <= '0;
			cmp_vld_s1 <= 1'b0;
			idx_s1     <= '0;
		end else begin
			cmp_vld_s1 <= scan_rd;
			if (in_fire) begin
				rd_idx_q <= '0;
			end else if (scan_rd) begin
				rd_idx_q <= rd_idx_q + IW'(1);
				idx_s1   <= rd_idx_q;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hit_found_q   <= 1'b0;
			empty_found_q <= 1'b0;
		end else if (in_fire) begin
			hit_found_q   <= 1'b0;
			empty_found_q <= 1'b0;
		end else if (cmp_vld_s1) begin
			if (!hit_found_q && cmp_valid && rd_data_s1 == page) hit_found_q <= 1'b1;
			if (!empty_found_q && !cmp_valid) empty_found_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (cmp_vld_s1) begin
			if (!hit_found_q && cmp_valid && rd_data_s1 == page) begin
				hit_idx_q  <= idx_s1;
				hit_rank_q <= cmp_rank;
			end
			if (!empty_found_q && !cmp_valid) empty_idx_q <= idx_s1;
			if (idx_s1 == '0 || cmp_rank > best_rank_q) begin
				best_rank_q <= cmp_rank;
				vic_idx_q   <= idx_s1;
				vic_page_q  <= rd_data_s1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
			for (int i = 0; i < MAX_FRAMES; i++) rank_q[i] <= '0;
		end else if (upd_go) begin
			for (int i = 0; i < MAX_FRAMES; i++) begin
				if (CW'(i) < n_q && IW'(i) != upd_frame && valid_q[i] &&
				    (upd_fill || rank_q[i] < upd_old_rank) && rank_q[i] < RANK_MAX) begin
					rank_q[i] <= rank_q[i] + IW'(1);
				end
			end
			rank_q[upd_frame]  <= '0;
			valid_q[upd_frame] <= 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fault_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (upd_go) begin
				out_valid_q <= 1'b1;
				if (!hit_found_q && fault_q != '1) fault_q <= fault_q + lru_pkg::fault_t'(1);
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (upd_go) begin
			hit_q      <= hit_found_q;
			frame_q    <= frame_ext[lru_pkg::FRAME_W-1:0];
			ev_valid_q <= !hit_found_q && !empty_found_q;
			ev_page_q  <= (!hit_found_q && !empty_found_q) ? vic_page_q : '0;
		end
	end

	assign out_valid     = out_valid_q;
	assign hit           = hit_q;
	assign frame         = frame_q;
	assign evicted_valid = ev_valid_q;
	assign evicted_page  = ev_page_q;
	assign fault_count   = fault_q;

	`LRU_ASSERT_SAME(a_hit_no_evict, out_valid_q && hit_q, !ev_valid_q, "hit beat reports an eviction")
	`LRU_ASSERT_SAME(a_evict_page_zero, out_valid_q && !ev_valid_q, ev_page_q == '0, "evicted page set without eviction")
	`LRU_ASSERT_SAME(a_scan_in_range, state_q == lru_pkg::ST_SCAN, CW'(rd_idx_q) < n_q, "scan index beyond active frames")
	`LRU_ASSERT_NEXT(a_update_mru, upd_go, valid_q[$past(upd_frame)] && rank_q[$past(upd_frame)] == '0, "updated frame not valid and most recent")

endmodule
